FILE: rtl/core/ohrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting history ring buffer package
// Word types, operation codes and sizes shared by the ring buffer modules.
// ----------------------------------------------------------------------------
package ohrb_pkg;

  localparam int DEPTH  = 16;
  localparam int WIDTH  = 32;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FIRST = 2'd2,
    MODE_NEXT  = 2'd3
  } mode_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef struct packed {
    mode_t             mode;
    logic [WIDTH-1:0]  write_data;
    logic [SLOT_W-1:0] element_index;
    logic [SLOT_W-1:0] position_in;
  } in_word_t;

  typedef struct packed {
    logic [WIDTH-1:0]  read_data;
    logic              status;
    logic [SLOT_W-1:0] position_out;
  } out_word_t;

  typedef struct packed {
    logic op_put;
    logic op_read;
    logic op_first;
    logic op_next;
  } ohrb_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/overwriting_history_ring_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting history ring buffer
// Keeps the last DEPTH words written and never refuses a put.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low. Its result
// appears on out_word in the next cycle, for exactly one cycle, with out_strobe
// high; the receiver cannot stall it. Every command costs one memory access,
// so a new command may follow in every cycle and results stream at one per
// cycle. Busy is high only in the first cycle after reset; the store reads as
// zero from reset on through a valid bit per slot, with no clearing pass.
// ----------------------------------------------------------------------------
module overwriting_history_ring_buffer
  import ohrb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_strobe,
  output out_word_t     out_word
);

  ohrb_cmd_t cmd;

  ohrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .mode       (in_word.mode),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  ohrb_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

FILE: rtl/core/ohrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ring buffer controller
// Accepts commands, decodes the mode into datapath operations and marks
// the cycle in which the result is presented.
// ----------------------------------------------------------------------------
module ohrb_ctrl
  import ohrb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire mode_t mode,
  output logic       busy,
  output logic       out_strobe,
  output ohrb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_INIT   = 3'b001,
    ST_IDLE   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy       = (state_r == ST_INIT);
  assign accept     = start & ~busy;
  assign out_strobe = (state_r == ST_RESULT);

  always_comb begin
    unique case (state_r)
      ST_INIT:   state_nxt = ST_IDLE;
      ST_IDLE:   state_nxt = accept ? ST_RESULT : ST_IDLE;
      ST_RESULT: state_nxt = accept ? ST_RESULT : ST_IDLE;
      default:   state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    if (accept) begin
      unique case (mode)
        MODE_PUT:   cmd.op_put   = 1'b1;
        MODE_READ:  cmd.op_read  = 1'b1;
        MODE_FIRST: cmd.op_first = 1'b1;
        MODE_NEXT:  cmd.op_next  = 1'b1;
        default:    cmd          = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ohrb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ring buffer datapath
// Holds the store, the write slot and the fill count, and forms the result
// word of each operation in an output register.
// ----------------------------------------------------------------------------
module ohrb_datapath
  import ohrb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ohrb_cmd_t cmd,
  input  wire in_word_t  in_word,
  output out_word_t      out_word
);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [SLOT_W-1:0] wslot_r;
  logic [CNT_W-1:0]  fill_r;

  logic [WIDTH-1:0]  rd_q_r;
  logic              rd_vld_r;
  logic              zero_r;
  logic              status_r;
  logic [SLOT_W-1:0] pos_r;

  logic              exec;
  logic              full;
  logic [SLOT_W-1:0] next_slot;
  logic [SLOT_W-1:0] rd_addr;
  logic              not_found;
  logic [SLOT_W-1:0] pos_nxt;

  assign exec      = cmd.op_put | cmd.op_read | cmd.op_first | cmd.op_next;
  assign full      = (fill_r == CNT_W'(DEPTH));
  assign next_slot = in_word.position_in + SLOT_W'(1);

  always_comb begin
    rd_addr   = '0;
    not_found = 1'b0;
    pos_nxt   = '0;
    if (cmd.op_read) begin
      rd_addr   = full ? (wslot_r + in_word.element_index) : in_word.element_index;
      not_found = ({1'b0, in_word.element_index} >= fill_r);
    end else if (cmd.op_first) begin
      rd_addr = full ? wslot_r : '0;
      pos_nxt = rd_addr;
    end else if (cmd.op_next) begin
      rd_addr   = next_slot;
      not_found = (next_slot == wslot_r);
      pos_nxt   = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_put) begin
      mem[wslot_r] <= in_word.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
      zero_r   <= cmd.op_put | not_found;
      status_r <= not_found ? STATUS_NOT_FOUND : STATUS_OK;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      wslot_r <= '0;
      fill_r  <= '0;
    end else if (cmd.op_put) begin
      valid_r[wslot_r] <= 1'b1;
      wslot_r          <= wslot_r + SLOT_W'(1);
      if (!full) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  // Slots never written since reset read as zero.
  assign out_word.read_data    = (zero_r | ~rd_vld_r) ? '0 : rd_q_r;
  assign out_word.status       = status_r;
  assign out_word.position_out = pos_r;

endmodule
`default_nettype wire
